/* sv/eod_pkg.sv */
// Shared types and constants for the envelope onset detector.
// Used by eod_envelope, eod_detect and envelope_onset_detector_top; no dependencies.
package eod_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 16;
    localparam int ENV_W      = 16;
    localparam int THR_W      = 15;
    localparam int GAP_W      = 11;
    localparam int HOLD_W     = 16;
    localparam int POS_W      = 32;
    localparam int NUM_W      = 9;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int FULL_SCALE = 32768;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_ONSET_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD_GAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_LENGTH  = 2'd2;

    localparam logic [THR_W-1:0]  THR_RESET  = 15'd328;
    localparam logic [GAP_W-1:0]  GAP_RESET  = 11'd2000;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd2500;

    // per-word control carried down the pipeline
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             sub_en;
        logic             env_en;
        logic             chk;
        logic [POS_W-1:0] pos;
    } eod_ctrl_t;

endpackage

/* sv/eod_envelope.sv */
// Magnitude window memory, running sum and envelope scaling for the onset detector.
// Depends on eod_pkg.
module eod_envelope #(
    parameter int WINDOW_LEN    = 1024,
    parameter int HISTORY_DEPTH = 2048,
    localparam int WPW = $clog2(WINDOW_LEN),
    localparam int HPW = $clog2(HISTORY_DEPTH)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic                       accept,
    input  logic [eod_pkg::MAG_W-1:0]  mag,
    input  logic [WPW-1:0]             win_ptr,
    input  eod_pkg::eod_ctrl_t         ctrl0,
    input  logic [HPW-1:0]             hptr0,
    input  logic [HPW-1:0]             hidx0,
    output eod_pkg::eod_ctrl_t         ctrl2,
    output logic [HPW-1:0]             hptr2,
    output logic [HPW-1:0]             hidx2,
    output logic [eod_pkg::ENV_W-1:0]  env
);

    localparam int SUMW  = $clog2(eod_pkg::FULL_SCALE * WINDOW_LEN + 1);
    localparam int LOGW  = $clog2(WINDOW_LEN);
    localparam int SHIFT = SUMW + LOGW;
    localparam int MW    = SUMW + 2;
    localparam int PRODW = SUMW + MW;
    // ceil(2^SHIFT / WINDOW_LEN): exact floor division for any sum below 2^SUMW
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

    logic [eod_pkg::MAG_W-1:0] win_mem [WINDOW_LEN];
    logic [eod_pkg::MAG_W-1:0] win_rd_reg;

    eod_pkg::eod_ctrl_t        ctrl1_reg;
    logic [eod_pkg::MAG_W-1:0] mag1_reg;
    logic [HPW-1:0]            hptr1_reg;
    logic [HPW-1:0]            hidx1_reg;

    eod_pkg::eod_ctrl_t        ctrl2_reg;
    logic [HPW-1:0]            hptr2_reg;
    logic [HPW-1:0]            hidx2_reg;
    logic [SUMW-1:0]           sum2_reg;

    logic [SUMW-1:0]           sum_reg;
    logic [SUMW:0]             sum_sub;
    logic [SUMW-1:0]           sum_next;
    logic [PRODW-1:0]          prod_reg;

    // read old entry and write new magnitude at the same slot
    always_ff @(posedge aclk) begin
        if (accept) begin
            win_rd_reg       <= win_mem[win_ptr];
            win_mem[win_ptr] <= mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
        end else if (advance) begin
            ctrl1_reg <= ctrl0;
            ctrl2_reg <= ctrl1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mag1_reg  <= mag;
            hptr1_reg <= hptr0;
            hidx1_reg <= hidx0;
            hptr2_reg <= hptr1_reg;
            hidx2_reg <= hidx1_reg;
            sum2_reg  <= sum_next;
            prod_reg  <= sum2_reg * RECIP;
        end
    end

    // drop the oldest magnitude once the window is full, then add the new one
    always_comb begin
        sum_sub  = {1'b0, sum_reg}
                 - (ctrl1_reg.sub_en ? (SUMW+1)'(win_rd_reg) : '0);
        sum_next = SUMW'(sum_sub + (SUMW+1)'(mag1_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (advance && ctrl1_reg.valid) begin
            sum_reg <= ctrl1_reg.last ? '0 : sum_next;
        end
    end

    assign ctrl2 = ctrl2_reg;
    assign hptr2 = hptr2_reg;
    assign hidx2 = hidx2_reg;
    assign env   = prod_reg[SHIFT +: eod_pkg::ENV_W];

endmodule

/* sv/eod_detect.sv */
// Envelope history memory, rise comparison, holdoff and onset counting.
// Depends on eod_pkg; fed by eod_envelope.
module eod_detect #(
    parameter int HISTORY_DEPTH = 2048,
    parameter int MAX_ONSETS    = 256,
    localparam int HPW = $clog2(HISTORY_DEPTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  eod_pkg::eod_ctrl_t          ctrl2,
    input  logic [HPW-1:0]              hptr2,
    input  logic [HPW-1:0]              hidx2,
    input  logic [eod_pkg::ENV_W-1:0]   env,
    input  logic [eod_pkg::THR_W-1:0]   threshold,
    input  logic [eod_pkg::HOLD_W-1:0]  holdoff_len,
    output logic                        fire,
    output logic [eod_pkg::POS_W-1:0]   onset_pos,
    output logic [eod_pkg::NUM_W-1:0]   onset_num
);

    localparam logic [eod_pkg::NUM_W-1:0] MAXN = eod_pkg::NUM_W'(MAX_ONSETS);

    logic [eod_pkg::ENV_W-1:0]  hist_mem [HISTORY_DEPTH];
    logic [eod_pkg::ENV_W-1:0]  hist_rd_reg;
    logic                       fwd_reg;
    logic [eod_pkg::ENV_W-1:0]  fwd_data_reg;

    eod_pkg::eod_ctrl_t         ctrl3_reg;
    logic [HPW-1:0]             hptr3_reg;
    logic [eod_pkg::HOLD_W-1:0] holdoff_reg;
    logic [eod_pkg::NUM_W-1:0]  onsets_reg;

    logic [eod_pkg::ENV_W-1:0]  env_h;
    logic [eod_pkg::ENV_W:0]    limit;
    logic                       checked;

    always_ff @(posedge aclk) begin
        if (advance) begin
            hist_rd_reg <= hist_mem[hidx2];
            if (ctrl3_reg.valid && ctrl3_reg.env_en) begin
                hist_mem[hptr3_reg] <= env;
            end
            hptr3_reg    <= hptr2;
            fwd_data_reg <= env;
        end
    end

    // forward the envelope being written when the next word reads that slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl3_reg <= '0;
            fwd_reg   <= 1'b0;
        end else if (advance) begin
            ctrl3_reg <= ctrl2;
            fwd_reg   <= ctrl3_reg.valid && ctrl3_reg.env_en && (hptr3_reg == hidx2);
        end
    end

    always_comb begin
        env_h   = fwd_reg ? fwd_data_reg : hist_rd_reg;
        limit   = {1'b0, env_h} + (eod_pkg::ENV_W+1)'(threshold);
        checked = ctrl3_reg.valid && ctrl3_reg.chk;
        fire    = checked && (holdoff_reg == '0) && (onsets_reg < MAXN)
                && ({1'b0, env} > limit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            holdoff_reg <= '0;
            onsets_reg  <= '0;
        end else if (advance && ctrl3_reg.valid) begin
            priority if (ctrl3_reg.last) begin
                holdoff_reg <= '0;
                onsets_reg  <= '0;
            end else if (checked && holdoff_reg != '0) begin
                holdoff_reg <= holdoff_reg - 1'b1;
            end else if (fire) begin
                holdoff_reg <= holdoff_len;
                onsets_reg  <= onsets_reg + 1'b1;
            end
        end
    end

    assign onset_pos = ctrl3_reg.pos;
    assign onset_num = onsets_reg + 1'b1;

    a_onset_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        onsets_reg <= MAXN)
        else $error("onset count above limit");

    a_fire_arms_holdoff: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && fire && !ctrl3_reg.last |=>
            holdoff_reg == $past(holdoff_len) && onsets_reg == $past(onsets_reg) + 1'b1)
        else $error("onset did not arm holdoff or count");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(ctrl3_reg) && $stable(holdoff_reg) && $stable(onsets_reg))
        else $error("detect stage moved while stalled");

    a_stream_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ctrl3_reg.valid && ctrl3_reg.last |=>
            onsets_reg == '0 && holdoff_reg == '0)
        else $error("stream end did not clear detect state");

endmodule

/* sv/envelope_onset_detector_top.sv */
// Top level of the envelope onset detector: input handshake, stream counters,
// configuration registers and result register. Depends on eod_pkg, eod_envelope, eod_detect.
//
// Usage
//   Input channel (s_): one signed 16-bit audio word per handshake; s_stream_end marks
//   the final word of a stream, after which all counters and history restart.
//   Result channel (m_): one word per detected onset, giving the sample index where
//   the envelope rise begins and the onset's ordinal within the stream.
//   Configuration: cfg_wr_en/cfg_index/cfg_wdata write threshold, lookahead gap and
//   holdoff length; write only while no word is in flight.
// Timing
//   Throughput is one input word per clock while m_ready does not stall the pipeline, set by
//   the single read-modify-write of the running sum and one read plus one write per cycle on
//   each of the two memories. A result passes ctrl1_reg, ctrl2_reg and ctrl3_reg into m_valid.
// Reset and stalls
//   aresetn (synchronous, active low) clears counters, running sum, holdoff, onset count
//   and pipeline valids, and loads the register defaults. The window and history
//   memories are not cleared: no entry is read before it is written in the same stream,
//   so the block is ready the cycle after reset.
//   While a result is held on m_ and m_ready is low, the whole pipeline holds and
//   s_ready drops; when m_ready is high the next word is taken in the same cycle.
module envelope_onset_detector_top #(
    parameter int WINDOW_LEN    = 1024,
    parameter int HISTORY_DEPTH = 2048,
    parameter int MAX_ONSETS    = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [eod_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                            s_stream_end,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [eod_pkg::POS_W-1:0]       m_onset_position,
    output logic [eod_pkg::NUM_W-1:0]       m_onset_number,
    input  logic                            cfg_wr_en,
    input  logic [eod_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [eod_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int WPW   = $clog2(WINDOW_LEN);
    localparam int HPW   = $clog2(HISTORY_DEPTH);
    localparam int WARMW = $clog2(WINDOW_LEN + HISTORY_DEPTH + 1);
    localparam logic [WARMW-1:0] WARM_MAX = WARMW'(WINDOW_LEN + HISTORY_DEPTH);
    localparam logic [WPW-1:0]   WIN_LAST = WPW'(WINDOW_LEN - 1);
    localparam logic [HPW-1:0]   HIST_LAST = HPW'(HISTORY_DEPTH - 1);

    // configuration
    logic [eod_pkg::THR_W-1:0]  thr_reg;
    logic [eod_pkg::GAP_W-1:0]  gap_reg;
    logic [eod_pkg::HOLD_W-1:0] hold_reg;

    // stream counters
    logic [WARMW-1:0]           warm_reg;
    logic [WPW-1:0]             win_ptr_reg;
    logic [HPW-1:0]             hist_ptr_reg;
    logic [eod_pkg::POS_W-1:0]  count_reg;

    // result register
    logic                       m_valid_reg;
    logic [eod_pkg::POS_W-1:0]  m_pos_reg;
    logic [eod_pkg::NUM_W-1:0]  m_num_reg;

    logic                       advance;
    logic                       accept;
    logic [eod_pkg::MAG_W-1:0]  raw;
    logic [eod_pkg::MAG_W-1:0]  mag;
    logic [HPW-1:0]             gap_eff;
    logic [HPW:0]               hsum;
    logic [HPW-1:0]             hidx;
    logic                       env_en;
    logic                       sub_en;
    logic                       chk;
    eod_pkg::eod_ctrl_t         ctrl0;

    eod_pkg::eod_ctrl_t         ctrl2;
    logic [HPW-1:0]             hptr2;
    logic [HPW-1:0]             hidx2;
    logic [eod_pkg::ENV_W-1:0]  env;
    logic                       fire;
    logic [eod_pkg::POS_W-1:0]  onset_pos;
    logic [eod_pkg::NUM_W-1:0]  onset_num;

    // hold everything while a result waits and the receiver is stalled
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= eod_pkg::THR_RESET;
            gap_reg  <= eod_pkg::GAP_RESET;
            hold_reg <= eod_pkg::HOLD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                eod_pkg::REG_ONSET_THRESHOLD: thr_reg  <= cfg_wdata[eod_pkg::THR_W-1:0];
                eod_pkg::REG_LOOKAHEAD_GAP:   gap_reg  <= cfg_wdata[eod_pkg::GAP_W-1:0];
                eod_pkg::REG_HOLDOFF_LENGTH:  hold_reg <= cfg_wdata[eod_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // magnitude in Q1.15; full negative scale maps to 1.0
        raw    = s_sample;
        mag    = raw[eod_pkg::MAG_W-1] ? (~raw + 1'b1) : raw;
        // clip the gap to what the history can hold
        gap_eff = (32'(gap_reg) > 32'(HISTORY_DEPTH - 1)) ? HIST_LAST : HPW'(gap_reg);
        // history slot written gap envelopes ago
        hsum   = {1'b0, hist_ptr_reg} + (HPW+1)'(HISTORY_DEPTH) - {1'b0, gap_eff};
        hidx   = (hsum >= (HPW+1)'(HISTORY_DEPTH))
               ? HPW'(hsum - (HPW+1)'(HISTORY_DEPTH)) : HPW'(hsum);
        env_en = 32'(warm_reg) >= 32'(WINDOW_LEN - 1);
        sub_en = 32'(warm_reg) >= 32'(WINDOW_LEN);
        chk    = env_en && (gap_eff != '0)
               && (32'(warm_reg) >= 32'(gap_eff) + 32'(WINDOW_LEN - 1));
        ctrl0.valid  = accept;
        ctrl0.last   = s_stream_end;
        ctrl0.sub_en = sub_en;
        ctrl0.env_en = env_en;
        ctrl0.chk    = chk;
        ctrl0.pos    = count_reg - 32'(WINDOW_LEN - 1) - 32'(gap_eff);
    end

    // advance stream counters per accepted word (history pointer only once env_en); restart after the last one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warm_reg     <= '0;
            win_ptr_reg  <= '0;
            hist_ptr_reg <= '0;
            count_reg    <= '0;
        end else if (accept) begin
            if (s_stream_end) begin
                warm_reg     <= '0;
                win_ptr_reg  <= '0;
                hist_ptr_reg <= '0;
                count_reg    <= '0;
            end else begin
                win_ptr_reg <= (win_ptr_reg == WIN_LAST) ? '0 : win_ptr_reg + 1'b1;
                if (env_en) begin
                    hist_ptr_reg <= (hist_ptr_reg == HIST_LAST) ? '0 : hist_ptr_reg + 1'b1;
                end
                count_reg <= count_reg + 1'b1;
                if (warm_reg < WARM_MAX) begin
                    warm_reg <= warm_reg + 1'b1;
                end
            end
        end
    end

    eod_envelope #(
        .WINDOW_LEN    (WINDOW_LEN),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_envelope (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .accept  (accept),
        .mag     (mag),
        .win_ptr (win_ptr_reg),
        .ctrl0   (ctrl0),
        .hptr0   (hist_ptr_reg),
        .hidx0   (hidx),
        .ctrl2   (ctrl2),
        .hptr2   (hptr2),
        .hidx2   (hidx2),
        .env     (env)
    );

    eod_detect #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_ONSETS    (MAX_ONSETS)
    ) u_detect (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .ctrl2       (ctrl2),
        .hptr2       (hptr2),
        .hidx2       (hidx2),
        .env         (env),
        .threshold   (thr_reg),
        .holdoff_len (hold_reg),
        .fire        (fire),
        .onset_pos   (onset_pos),
        .onset_num   (onset_num)
    );

    // result register: load on an onset, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && fire) begin
            m_pos_reg <= onset_pos;
            m_num_reg <= onset_num;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_onset_position = m_pos_reg;
    assign m_onset_number   = m_num_reg;

endmodule
